### rtl/assert_macros.svh
// Assertion macros used by the top level of the escape decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/dlesc_pkg.sv
// Types and constants shared by the escape decoder modules.
package dlesc_pkg;

    // Character codes and limits used by the decoder.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CODE_MIN       = 8'h20;
    localparam logic [7:0] CODE_MAX       = 8'h7E;
    localparam logic [7:0] ACC_MAX        = 8'hFF;

    // Default depth of the result buffer.
    localparam int RESULT_DEPTH = 8;

    // Escape state, one-hot.
    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_DIGITS = 3'b100
    } t_mode;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_name;
        logic       decode_error;
    } t_result;

    // Results produced by one input word.
    typedef struct packed {
        t_result    res0;
        t_result    res1;
        logic [1:0] count;
    } t_dec_out;

endpackage

### rtl/dns_label_escape_decoder.sv
// Top level of the DNS name escape decoder: input stage, decode step, result buffer.
// Path: an accepted word is held in the input stage, decoded combinationally from it and
// written to the result buffer, from which its first result word is offered.
// Throughput: one input word per cycle; a word with two results takes two output transfers, and
// s_axis_tready falls when the buffer lacks room for two results each of staged and new word.
// Reset: synchronous, active low; clears the escape state, the stage and the buffer.
`include "assert_macros.svh"

module dns_label_escape_decoder #(
    parameter int DEPTH = dlesc_pkg::RESULT_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] has_byte, [1] decode_error
    output logic       m_axis_tlast    // end_of_name
);
    import dlesc_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] LIMIT = (CW + 1)'(DEPTH - 2);

    logic          r_stage_valid;
    logic [7:0]    r_stage_byte;
    logic          r_stage_last;
    t_dec_out      w_dec;
    t_result       w_rd_data;
    logic [CW-1:0] w_fifo_count;
    logic          w_accept;

    // Room for the staged word and the new one, two results each.
    assign s_axis_tready = ({1'b0, w_fifo_count} + (r_stage_valid ? (CW + 1)'(2) : '0))
                           <= LIMIT;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else begin
            r_stage_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_stage_byte <= s_axis_tdata;
            r_stage_last <= s_axis_tlast;
        end
    end

    dlesc_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_stage_valid),
        .i_byte  (r_stage_byte),
        .i_last  (r_stage_last),
        .o_dec   (w_dec)
    );

    dlesc_result_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (w_dec.count),
        .i_wr_data0 (w_dec.res0),
        .i_wr_data1 (w_dec.res1),
        .o_rd_valid (m_axis_tvalid),
        .i_rd_ready (m_axis_tready),
        .o_rd_data  (w_rd_data),
        .o_count    (w_fifo_count)
    );

    assign m_axis_tdata = w_rd_data.out_byte;
    assign m_axis_tuser = {w_rd_data.decode_error, w_rd_data.has_byte};
    assign m_axis_tlast = w_rd_data.end_of_name;

    // The decode step never writes more results than the buffer has room for.
    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, r_stage_valid, ({1'b0, w_fifo_count} + (CW + 1)'(w_dec.count)) <= (CW + 1)'(DEPTH))
    // No results appear without a staged word.
    `ASSERT_IMPLIES(a_no_idle_results, i_clk, i_rst_n, !r_stage_valid, w_dec.count == 2'd0)
    // An error word is always the final word of its name.
    `ASSERT_IMPLIES(a_error_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && !m_axis_tuser[0])
    // A word without a character carries a zero byte.
    `ASSERT_IMPLIES(a_empty_is_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'h00)

endmodule

### rtl/dlesc_decode.sv
// Escape decoding step with its state registers; yields up to two results per word.
module dlesc_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output dlesc_pkg::t_dec_out o_dec
);
    import dlesc_pkg::*;

    t_mode      r_mode, n_mode;
    logic [7:0] r_acc, n_acc;
    logic       r_err, n_err;

    logic        w_is_digit;
    logic [3:0]  w_digit;
    logic [11:0] w_prod;
    t_result     w_res [2];
    logic [1:0]  w_cnt;
    logic        w_last_idx;

    assign w_is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign w_digit    = 4'(i_byte - CHAR_ZERO);
    // Accumulator times ten plus the new digit, built from two shifts.
    assign w_prod     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {8'h00, w_digit};

    // Next state and the results of the current word.
    always_comb begin
        n_mode     = r_mode;
        n_acc      = r_acc;
        n_err      = r_err;
        w_cnt      = 2'd0;
        w_res[0]   = '0;
        w_res[1]   = '0;
        w_last_idx = 1'b0;
        if (i_valid) begin
            if (!r_err) begin
                case (r_mode)
                    MODE_ESC: begin
                        if (i_byte == CHAR_BACKSLASH || i_byte == CHAR_DOT) begin
                            n_mode = MODE_PLAIN;
                            w_res[w_cnt[0]] = '{out_byte: i_byte, has_byte: 1'b1,
                                                end_of_name: 1'b0, decode_error: 1'b0};
                            w_cnt = w_cnt + 2'd1;
                        end else if (w_is_digit) begin
                            n_acc  = {4'h0, w_digit};
                            n_mode = MODE_DIGITS;
                        end else begin
                            n_err  = 1'b1;
                            n_mode = MODE_PLAIN;
                        end
                    end
                    MODE_DIGITS: begin
                        if (w_is_digit) begin
                            n_acc = (w_prod > {4'h0, ACC_MAX}) ? ACC_MAX : w_prod[7:0];
                        end else begin
                            // A non-digit closes the code; a backslash reopens an escape, other bytes are plain text.
                            n_mode = MODE_PLAIN;
                            n_acc  = '0;
                            if (r_acc < CODE_MIN || r_acc > CODE_MAX) begin
                                n_err = 1'b1;
                            end else begin
                                w_res[w_cnt[0]] = '{out_byte: r_acc, has_byte: 1'b1,
                                                    end_of_name: 1'b0, decode_error: 1'b0};
                                w_cnt = w_cnt + 2'd1;
                                if (i_byte == CHAR_BACKSLASH) begin
                                    n_mode = MODE_ESC;
                                end else begin
                                    w_res[w_cnt[0]] = '{out_byte: i_byte, has_byte: 1'b1,
                                                        end_of_name: 1'b0,
                                                        decode_error: 1'b0};
                                    w_cnt = w_cnt + 2'd1;
                                end
                            end
                        end
                    end
                    default: begin
                        if (i_byte == CHAR_BACKSLASH) begin
                            n_mode = MODE_ESC;
                        end else begin
                            n_mode = MODE_PLAIN;
                            w_res[w_cnt[0]] = '{out_byte: i_byte, has_byte: 1'b1,
                                                end_of_name: 1'b0, decode_error: 1'b0};
                            w_cnt = w_cnt + 2'd1;
                        end
                    end
                endcase
            end

            // The end of the name closes any open escape and marks the final result.
            if (i_last) begin
                if (!n_err) begin
                    if (n_mode == MODE_DIGITS) begin
                        if (n_acc < CODE_MIN || n_acc > CODE_MAX) begin
                            n_err = 1'b1;
                        end else begin
                            w_res[w_cnt[0]] = '{out_byte: n_acc, has_byte: 1'b1,
                                                end_of_name: 1'b0, decode_error: 1'b0};
                            w_cnt = w_cnt + 2'd1;
                        end
                    end else if (n_mode == MODE_ESC) begin
                        n_err = 1'b1;
                    end
                end
                if (n_err) begin
                    w_res[w_cnt[0]] = '{out_byte: 8'h00, has_byte: 1'b0,
                                        end_of_name: 1'b1, decode_error: 1'b1};
                    w_cnt = w_cnt + 2'd1;
                end else if (w_cnt != 2'd0) begin
                    w_last_idx = (w_cnt == 2'd2);
                    w_res[w_last_idx].end_of_name = 1'b1;
                end else begin
                    w_res[0] = '{out_byte: 8'h00, has_byte: 1'b0,
                                 end_of_name: 1'b1, decode_error: 1'b0};
                    w_cnt = 2'd1;
                end
                n_mode = MODE_PLAIN;
                n_acc  = '0;
                n_err  = 1'b0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_acc  <= '0;
            r_err  <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_err  <= n_err;
        end
    end

    assign o_dec.res0  = w_res[0];
    assign o_dec.res1  = w_res[1];
    assign o_dec.count = w_cnt;

endmodule

### rtl/dlesc_result_fifo.sv
// Result buffer that takes up to two words per cycle and hands out one when i_rd_ready is high.
module dlesc_result_fifo #(
    parameter int DEPTH = dlesc_pkg::RESULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_wr_count,
    input  dlesc_pkg::t_result         i_wr_data0,
    input  dlesc_pkg::t_result         i_wr_data1,
    output logic                       o_rd_valid,
    input  logic                       i_rd_ready,
    output dlesc_pkg::t_result         o_rd_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import dlesc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   w_wp1;
    logic            w_rd;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign w_wp1 = ptr_inc(r_wp);
    assign w_rd  = o_rd_valid && i_rd_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count + CW'(i_wr_count) - CW'(w_rd);
        if (i_wr_count == 2'd1) begin
            n_wp = w_wp1;
        end else if (i_wr_count == 2'd2) begin
            n_wp = ptr_inc(w_wp1);
        end
        if (w_rd) begin
            n_rp = ptr_inc(r_rp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Storage writes, in order of the results.
    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wp] <= i_wr_data0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[w_wp1] <= i_wr_data1;
        end
    end

    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign o_count    = r_count;

endmodule
